[rtl/core/tchfe_pkg.sv]
package tchfe_pkg;

  // one input word: a record byte with its packet context
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] packet_length;
    logic        last_byte;
  } in_t;

  // one result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  name_byte;
    logic [1:0]  status;
    logic [7:0]  hs_type;
    logic [15:0] record_version;
    logic [15:0] cipher_first;
    logic [15:0] cipher_second;
    logic [7:0]  extension_count;
    logic [63:0] extension_bitmap;
    logic [7:0]  sni_length;
    logic [7:0]  alpn_length;
    logic        run_end;
  } out_t;

  // result kinds
  localparam logic [1:0] KIND_SNI     = 2'd0;
  localparam logic [1:0] KIND_ALPN    = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // packet status codes
  localparam logic [1:0] ST_CH    = 2'd0;
  localparam logic [1:0] ST_OTHER = 2'd1;
  localparam logic [1:0] ST_REJ   = 2'd2;
  localparam logic [1:0] ST_PEND  = 2'd3;

  // result queue between parser and ports
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // protocol constants
  localparam logic [7:0]  CT_HANDSHAKE = 8'd22;
  localparam logic [7:0]  HS_CLIENT    = 8'd1;
  localparam logic [7:0]  HS_SERVER    = 8'd2;
  localparam logic [7:0]  HS_CERT      = 8'd11;
  localparam logic [15:0] EXT_SNI      = 16'd0;
  localparam logic [15:0] EXT_ALPN     = 16'd16;
  localparam logic [15:0] EXT_MAP_TOP  = 16'h003f;
  localparam logic [7:0]  SNI_HOST     = 8'd0;

endpackage

[rtl/core/tchfe_parser.sv]
module tchfe_parser #(
  parameter logic [7:0] SNI_CAPTURE    = 8'd255,
  parameter logic [7:0] ALPN_CAPTURE   = 8'd31,
  parameter logic [7:0] MAX_EXTENSIONS = 8'd255
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  tchfe_pkg::in_t item,
  output logic           name_valid,
  output tchfe_pkg::out_t name_word,
  output logic           sum_valid,
  output tchfe_pkg::out_t sum_word
);

  // parse phases
  localparam logic [4:0] PH_HDR       = 5'd0;
  localparam logic [4:0] PH_HSTYPE    = 5'd1;
  localparam logic [4:0] PH_FIXED     = 5'd2;
  localparam logic [4:0] PH_SIDLEN    = 5'd3;
  localparam logic [4:0] PH_SID       = 5'd4;
  localparam logic [4:0] PH_CLEN      = 5'd5;
  localparam logic [4:0] PH_CIPH      = 5'd6;
  localparam logic [4:0] PH_COMPLEN   = 5'd7;
  localparam logic [4:0] PH_COMP      = 5'd8;
  localparam logic [4:0] PH_ELEN      = 5'd9;
  localparam logic [4:0] PH_EHDR      = 5'd10;
  localparam logic [4:0] PH_SNI_LIST  = 5'd11;
  localparam logic [4:0] PH_SNI_TYPE  = 5'd12;
  localparam logic [4:0] PH_SNI_NLEN  = 5'd13;
  localparam logic [4:0] PH_SNI_NAME  = 5'd14;
  localparam logic [4:0] PH_ALPN_LIST = 5'd15;
  localparam logic [4:0] PH_ALPN_PLEN = 5'd16;
  localparam logic [4:0] PH_ALPN_NAME = 5'd17;
  localparam logic [4:0] PH_ESKIP     = 5'd18;
  localparam logic [4:0] PH_DONE      = 5'd19;

  logic [15:0] off, acc, fbl, exsl, exl, ctype, ver, s1, s2;
  logic [4:0]  ph;
  logic [7:0]  hst, walked, snic, alpnc;
  logic [63:0] seen;
  logic [1:0]  pst;

  logic [15:0] off_next, acc_next, fbl_next, exsl_next, exl_next, ctype_next, ver_next;
  logic [15:0] s1_next, s2_next;
  logic [4:0]  ph_next;
  logic [7:0]  hst_next, walked_next, snic_next, alpnc_next;
  logic [63:0] seen_next;
  logic [1:0]  pst_next;

  // does a field of n bytes, starting after this byte, fit in the packet
  function automatic logic fits(input logic [15:0] pos, input logic [15:0] len,
                                input logic [15:0] n);
    logic [17:0] endp;
    endp = {2'b00, pos} + 18'd1 + {2'b00, n};
    return endp <= {2'b00, len};
  endfunction

  // parse step
  always_comb begin
    logic [7:0]  b;
    logic [15:0] len, v, idx;
    logic        done, rest, endx, walk;
    b    = item.data_byte;
    len  = item.packet_length;
    v    = '0;
    idx  = '0;
    done = 1'b0;
    rest = 1'b0;
    endx = 1'b0;
    walk = 1'b0;
    off_next = off; acc_next = acc; fbl_next = fbl; exsl_next = exsl; exl_next = exl;
    ctype_next = ctype; ver_next = ver; s1_next = s1; s2_next = s2; ph_next = ph;
    hst_next = hst; walked_next = walked; snic_next = snic; alpnc_next = alpnc;
    seen_next = seen; pst_next = pst;
    name_valid = 1'b0;
    name_word = '0;

    // shared body accounting inside the extension walk
    if (ph >= PH_EHDR && ph <= PH_ESKIP) begin
      if (exsl != '0) exsl_next = exsl - 16'd1;
      if (ph != PH_EHDR && exl != '0) exl_next = exl - 16'd1;
    end
    // shared field collection
    if (ph == PH_CLEN || ph == PH_ELEN || ph == PH_EHDR || ph == PH_SNI_LIST ||
        ph == PH_SNI_NLEN || ph == PH_ALPN_LIST) begin
      acc_next = {acc[7:0], b};
      if (fbl != '0) fbl_next = fbl - 16'd1;
      done = (fbl_next == '0);
    end

    unique case (ph)
      PH_HDR: begin
        if (off == 16'd0) pst_next = (b == tchfe_pkg::CT_HANDSHAKE) ? tchfe_pkg::ST_PEND
                                                                     : tchfe_pkg::ST_REJ;
        else if (off == 16'd1 || off == 16'd3) acc_next = {8'd0, b};
        else if (off == 16'd2) ver_next = {acc[7:0], b};
        else begin
          v = {acc[7:0], b};
          if (pst != tchfe_pkg::ST_PEND || ({1'b0, len} < 17'd5 + {1'b0, v}))
            pst_next = tchfe_pkg::ST_REJ;
          ph_next = PH_HSTYPE;
        end
      end
      PH_HSTYPE: begin
        if (pst == tchfe_pkg::ST_PEND && (b == tchfe_pkg::HS_CLIENT ||
            b == tchfe_pkg::HS_SERVER || b == tchfe_pkg::HS_CERT)) begin
          hst_next = b;
          if (b == tchfe_pkg::HS_CLIENT) begin
            pst_next = tchfe_pkg::ST_CH;
            ph_next  = PH_FIXED;
            fbl_next = 16'd37;
            acc_next = '0;
          end else begin
            pst_next = tchfe_pkg::ST_OTHER;
            ph_next  = PH_DONE;
          end
        end else begin
          pst_next = tchfe_pkg::ST_REJ;
          ph_next  = PH_DONE;
        end
      end
      PH_FIXED: begin
        if (fbl != '0) fbl_next = fbl - 16'd1;
        if (fbl_next == '0) ph_next = fits(off, len, 16'd1) ? PH_SIDLEN : PH_DONE;
      end
      PH_SIDLEN: begin
        if (!fits(off, len, {8'd0, b})) ph_next = PH_DONE;
        else if (b == 8'd0) begin
          if (fits(off, len, 16'd2)) begin
            ph_next = PH_CLEN; fbl_next = 16'd2; acc_next = '0;
          end else ph_next = PH_DONE;
        end else begin
          ph_next = PH_SID; fbl_next = {8'd0, b}; acc_next = '0;
        end
      end
      PH_SID: begin
        if (fbl != '0) fbl_next = fbl - 16'd1;
        if (fbl_next == '0) begin
          if (fits(off, len, 16'd2)) begin
            ph_next = PH_CLEN; fbl_next = 16'd2; acc_next = '0;
          end else ph_next = PH_DONE;
        end
      end
      PH_CLEN: begin
        if (done) begin
          v = acc_next;
          if (!fits(off, len, v)) ph_next = PH_DONE;
          else if (v == '0) ph_next = fits(off, len, 16'd1) ? PH_COMPLEN : PH_DONE;
          else begin
            ph_next = PH_CIPH; fbl_next = v; acc_next = '0; exsl_next = v;
          end
        end
      end
      PH_CIPH: begin
        idx = exsl - fbl;
        if (idx == 16'd0 || idx == 16'd2) acc_next = {8'd0, b};
        else if (idx == 16'd1 && exsl >= 16'd2) s1_next = {acc[7:0], b};
        else if (idx == 16'd3 && exsl >= 16'd4) s2_next = {acc[7:0], b};
        if (fbl != '0) fbl_next = fbl - 16'd1;
        if (fbl_next == '0) begin
          exsl_next = '0;
          ph_next = fits(off, len, 16'd1) ? PH_COMPLEN : PH_DONE;
        end
      end
      PH_COMPLEN: begin
        if (!fits(off, len, {8'd0, b})) ph_next = PH_DONE;
        else if (b == 8'd0) begin
          if (fits(off, len, 16'd2)) begin
            ph_next = PH_ELEN; fbl_next = 16'd2; acc_next = '0;
          end else ph_next = PH_DONE;
        end else begin
          ph_next = PH_COMP; fbl_next = {8'd0, b}; acc_next = '0;
        end
      end
      PH_COMP: begin
        if (fbl != '0) fbl_next = fbl - 16'd1;
        if (fbl_next == '0) begin
          if (fits(off, len, 16'd2)) begin
            ph_next = PH_ELEN; fbl_next = 16'd2; acc_next = '0;
          end else ph_next = PH_DONE;
        end
      end
      PH_ELEN: begin
        if (done) begin
          v = acc_next;
          if (!fits(off, len, v)) ph_next = PH_DONE;
          else begin
            exsl_next = v; walk = 1'b1;
          end
        end
      end
      PH_EHDR: begin
        if (done) begin
          v = acc_next;
          if (ctype <= tchfe_pkg::EXT_MAP_TOP) seen_next[ctype[5:0]] = 1'b1;
          if (!fits(off, len, v)) ph_next = PH_DONE;
          else begin
            walked_next = walked + 8'd1;
            exl_next = v;
            if (ctype == tchfe_pkg::EXT_SNI && v >= 16'd2) begin
              ph_next = PH_SNI_LIST; fbl_next = 16'd2; acc_next = '0;
            end else if (ctype == tchfe_pkg::EXT_ALPN && v >= 16'd2) begin
              ph_next = PH_ALPN_LIST; fbl_next = 16'd2; acc_next = '0;
            end else rest = 1'b1;
          end
        end else if (fbl_next == 16'd2) begin
          ctype_next = acc_next;
          acc_next = '0;
        end
      end
      PH_SNI_LIST: begin
        if (done) begin
          if (acc_next >= 16'd3 && exl_next >= 16'd3) ph_next = PH_SNI_TYPE;
          else rest = 1'b1;
        end
      end
      PH_SNI_TYPE: begin
        if (b == tchfe_pkg::SNI_HOST && exl_next >= 16'd2) begin
          ph_next = PH_SNI_NLEN; fbl_next = 16'd2; acc_next = '0;
        end else rest = 1'b1;
      end
      PH_SNI_NLEN: begin
        if (done) begin
          v = acc_next;
          if (v != '0 && v <= exl_next && snic == 8'd0) begin
            ph_next = PH_SNI_NAME; fbl_next = v; acc_next = '0;
          end else rest = 1'b1;
        end
      end
      PH_SNI_NAME: begin
        if (snic < SNI_CAPTURE) begin
          name_valid = 1'b1;
          name_word.kind = tchfe_pkg::KIND_SNI;
          name_word.name_byte = b;
          snic_next = snic + 8'd1;
        end
        if (fbl != '0) fbl_next = fbl - 16'd1;
        if (fbl_next == '0) rest = 1'b1;
      end
      PH_ALPN_LIST: begin
        if (done) begin
          if (acc_next >= 16'd1 && exl_next >= 16'd1) ph_next = PH_ALPN_PLEN;
          else rest = 1'b1;
        end
      end
      PH_ALPN_PLEN: begin
        if (b != 8'd0 && {8'd0, b} <= exl_next && alpnc == 8'd0) begin
          ph_next = PH_ALPN_NAME; fbl_next = {8'd0, b}; acc_next = '0;
        end else rest = 1'b1;
      end
      PH_ALPN_NAME: begin
        if (alpnc < ALPN_CAPTURE) begin
          name_valid = 1'b1;
          name_word.kind = tchfe_pkg::KIND_ALPN;
          name_word.name_byte = b;
          alpnc_next = alpnc + 8'd1;
        end
        if (fbl != '0) fbl_next = fbl - 16'd1;
        if (fbl_next == '0) rest = 1'b1;
      end
      PH_ESKIP: begin
        if (exl_next == '0) endx = 1'b1;
      end
      default: ph_next = PH_DONE;
    endcase

    // extension walk continuation chain
    if (rest) begin
      if (exl_next == '0) endx = 1'b1;
      else ph_next = PH_ESKIP;
    end
    if (endx) begin
      if (walked_next >= MAX_EXTENSIONS) ph_next = PH_DONE;
      else walk = 1'b1;
    end
    if (walk) begin
      if (exsl_next == '0 || !fits(off, len, 16'd4)) ph_next = PH_DONE;
      else begin
        ph_next = PH_EHDR; fbl_next = 16'd4; acc_next = '0;
      end
    end

    if (off != 16'hffff) off_next = off + 16'd1;
  end

  // summary word from the updated state
  always_comb begin
    logic ok;
    ok = (pst_next == tchfe_pkg::ST_CH) || (pst_next == tchfe_pkg::ST_OTHER);
    sum_valid = item.last_byte;
    sum_word = '0;
    sum_word.kind = tchfe_pkg::KIND_SUMMARY;
    sum_word.status = ok ? pst_next : tchfe_pkg::ST_REJ;
    sum_word.run_end = 1'b1;
    if (ok) begin
      sum_word.hs_type          = hst_next;
      sum_word.record_version   = ver_next;
      sum_word.cipher_first     = s1_next;
      sum_word.cipher_second    = s2_next;
      sum_word.extension_count  = walked_next;
      sum_word.extension_bitmap = seen_next;
      sum_word.sni_length       = snic_next;
      sum_word.alpn_length      = alpnc_next;
    end
  end

  // state registers; the last byte clears the packet context
  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      off <= '0; ph <= PH_HDR; acc <= '0; fbl <= '0; exsl <= '0; exl <= '0;
      ctype <= '0; ver <= '0; hst <= '0; s1 <= '0; s2 <= '0; walked <= '0;
      seen <= '0; snic <= '0; alpnc <= '0; pst <= tchfe_pkg::ST_REJ;
    end else if (step) begin
      off <= off_next; ph <= ph_next; acc <= acc_next; fbl <= fbl_next;
      exsl <= exsl_next; exl <= exl_next; ctype <= ctype_next; ver <= ver_next;
      hst <= hst_next; s1 <= s1_next; s2 <= s2_next; walked <= walked_next;
      seen <= seen_next; snic <= snic_next; alpnc <= alpnc_next; pst <= pst_next;
    end
  end

endmodule

[rtl/core/tchfe_queue.sv]
module tchfe_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_a,
  input  tchfe_pkg::out_t word_a,
  input  logic            wr_b,
  input  tchfe_pkg::out_t word_b,
  output logic            full,
  output logic            empty,
  input  logic            pop,
  output tchfe_pkg::out_t result,
  output logic [tchfe_pkg::QUEUE_AW:0] level
);

  tchfe_pkg::out_t slots [tchfe_pkg::QUEUE_DEPTH];
  logic [tchfe_pkg::QUEUE_AW-1:0] wptr, rptr;
  logic [tchfe_pkg::QUEUE_AW:0]   count, count_next;
  logic do_pop;
  logic [1:0] nwr;

  assign empty  = (count == '0);
  // room for two words is always kept open for the next byte
  assign full   = (count > (tchfe_pkg::QUEUE_AW + 1)'(tchfe_pkg::QUEUE_DEPTH - 2));
  assign result = slots[rptr];
  assign level  = count;
  assign do_pop = pop && !empty;
  assign nwr    = {1'b0, wr_a} + {1'b0, wr_b};

  always_comb begin
    count_next = count + {{(tchfe_pkg::QUEUE_AW-1){1'b0}}, nwr} -
                 {{tchfe_pkg::QUEUE_AW{1'b0}}, do_pop};
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0; rptr <= '0; count <= '0;
    end else begin
      wptr  <= wptr + nwr[tchfe_pkg::QUEUE_AW-1:0];
      rptr  <= rptr + {{(tchfe_pkg::QUEUE_AW-1){1'b0}}, do_pop};
      count <= count_next;
    end
  end

  // storage: second word lands after the first when both are written
  always_ff @(posedge clk) begin
    if (wr_a) slots[wptr] <= word_a;
    if (wr_b) slots[wr_a ? wptr + 1'b1 : wptr] <= word_b;
  end

endmodule

[rtl/core/tls_client_hello_field_extractor_core.sv]
// Channel  Handshake          Payload                 Note
// input    push / full        item   (tchfe_pkg::in_t)  one record byte per word
// result   empty / pop        result (tchfe_pkg::out_t) name bytes, then summary
//
// One input word per cycle, back to back while full is low; each byte is parsed in the cycle it is accepted.
// A byte yields up to two result words into a four-entry result queue.
// full rises when fewer than two queue slots are free; a stalled pop backs up
// into full only then. Synchronous reset empties the queue and clears parse state.
module tls_client_hello_field_extractor_core #(
  parameter logic [7:0] SNI_CAPTURE    = 8'd255,
  parameter logic [7:0] ALPN_CAPTURE   = 8'd31,
  parameter logic [7:0] MAX_EXTENSIONS = 8'd255
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  tchfe_pkg::in_t  item,
  output logic            empty,
  input  logic            pop,
  output tchfe_pkg::out_t result
);

  logic            step;
  logic            name_valid, sum_valid;
  tchfe_pkg::out_t name_word, sum_word;
  logic [tchfe_pkg::QUEUE_AW:0] level;

  assign step = push && !full;

  // front: byte parser
  tchfe_parser #(
    .SNI_CAPTURE   (SNI_CAPTURE),
    .ALPN_CAPTURE  (ALPN_CAPTURE),
    .MAX_EXTENSIONS(MAX_EXTENSIONS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (item),
    .name_valid(name_valid),
    .name_word (name_word),
    .sum_valid (sum_valid),
    .sum_word  (sum_word)
  );

  // back: result queue
  tchfe_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr_a  (step && name_valid),
    .word_a(name_word),
    .wr_b  (step && sum_valid),
    .word_b(sum_word),
    .full  (full),
    .empty (empty),
    .pop   (pop),
    .result(result),
    .level (level)
  );

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= (tchfe_pkg::QUEUE_AW + 1)'(tchfe_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");
  a_last_gives_word: assert property (@(posedge clk) disable iff (rst)
    step && item.last_byte |=> !empty)
    else $error("last byte produced no summary");
  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    full |-> !empty)
    else $error("full while empty");
`endif

endmodule

[bench/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // parser phases
  typedef enum logic [4:0] {
    P_HDR, P_HSTYPE, P_FIXED, P_SIDLEN, P_SID, P_CLEN, P_CIPH, P_COMPLEN, P_COMP,
    P_ELEN, P_EHDR, P_SNI_LIST, P_SNI_TYPE, P_SNI_NLEN, P_SNI_NAME, P_ALPN_LIST,
    P_ALPN_PLEN, P_ALPN_NAME, P_ESKIP, P_DONE
  } phase_e;

  localparam logic [7:0] SNI_CAP  = 8'd255;
  localparam logic [7:0] ALPN_CAP = 8'd31;
  localparam logic [7:0] EXT_MAX  = 8'd255;
  localparam int LIMIT = 400000;

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic pop = 0;
  logic full, empty;
  tchfe_pkg::in_t item = '0;
  tchfe_pkg::out_t result;

  tls_client_hello_field_extractor_core uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [15:0] m_off, m_acc, m_fleft, m_exts, m_ext, m_etype, m_ver, m_s1, m_s2;
  phase_e m_ph;
  logic [7:0] m_hs, m_cnt, m_sni, m_alpn;
  logic [63:0] m_map;
  logic [1:0] m_st;
  int unsigned m_next, m_len;

  tchfe_pkg::out_t expected_words[$];
  int errors = 0;
  int cycles = 0;
  bit hold_off = 0;
  int gap_max = 4;
  int ext_body_max = 6;

  function automatic void clear_pkt();
    m_off = 0; m_ph = P_HDR; m_acc = 0; m_fleft = 0; m_exts = 0; m_ext = 0;
    m_etype = 0; m_ver = 0; m_hs = 0; m_s1 = 0; m_s2 = 0; m_cnt = 0; m_map = 0;
    m_sni = 0; m_alpn = 0; m_st = tchfe_pkg::ST_REJ;
  endfunction

  function automatic bit fits(int unsigned n);
    return m_next + n <= m_len;
  endfunction

  function automatic void start_field(phase_e p, logic [15:0] n);
    m_ph = p; m_fleft = n; m_acc = 0;
  endfunction

  function automatic bit collect(logic [7:0] b);
    m_acc = {m_acc[7:0], b};
    if (m_fleft > 0) m_fleft--;
    return m_fleft == 0;
  endfunction

  function automatic void begin_walk();
    if (m_exts == 0 || !fits(4)) m_ph = P_DONE;
    else start_field(P_EHDR, 4);
  endfunction

  function automatic void end_ext();
    if (m_cnt >= EXT_MAX) m_ph = P_DONE;
    else begin_walk();
  endfunction

  function automatic void begin_rest();
    if (m_ext == 0) end_ext();
    else m_ph = P_ESKIP;
  endfunction

  function automatic void begin_elen();
    if (fits(2)) start_field(P_ELEN, 2); else m_ph = P_DONE;
  endfunction

  function automatic void begin_complen();
    if (fits(1)) m_ph = P_COMPLEN; else m_ph = P_DONE;
  endfunction

  function automatic void begin_clen();
    if (fits(2)) start_field(P_CLEN, 2); else m_ph = P_DONE;
  endfunction

  function automatic void eat_body();
    if (m_exts > 0) m_exts--;
    if (m_ph != P_EHDR && m_ext > 0) m_ext--;
  endfunction

  function automatic void name_word(logic [1:0] k, logic [7:0] b);
    tchfe_pkg::out_t w;
    w = '0; w.kind = k; w.name_byte = b;
    expected_words.push_back(w);
  endfunction

  // advance the parser model by one byte and queue its words
  function automatic void parse_byte(tchfe_pkg::in_t it);
    logic [7:0] b;
    logic [15:0] v, idx;
    int unsigned pos;
    tchfe_pkg::out_t s;
    bit ok;
    b = it.data_byte; pos = m_off;
    m_len = it.packet_length; m_next = pos + 1;
    case (m_ph)
      P_HDR: begin
        if (pos == 0) m_st = (b == tchfe_pkg::CT_HANDSHAKE) ? tchfe_pkg::ST_PEND
                                                            : tchfe_pkg::ST_REJ;
        else if (pos == 1 || pos == 3) m_acc = b;
        else if (pos == 2) m_ver = {m_acc[7:0], b};
        else begin
          v = {m_acc[7:0], b};
          if (m_st != tchfe_pkg::ST_PEND || m_len < 5 + int'(v)) m_st = tchfe_pkg::ST_REJ;
          m_ph = P_HSTYPE;
        end
      end
      P_HSTYPE: begin
        if (m_st == tchfe_pkg::ST_PEND && (b == tchfe_pkg::HS_CLIENT ||
            b == tchfe_pkg::HS_SERVER || b == tchfe_pkg::HS_CERT)) begin
          m_hs = b;
          m_st = (b == tchfe_pkg::HS_CLIENT) ? tchfe_pkg::ST_CH : tchfe_pkg::ST_OTHER;
          if (b == tchfe_pkg::HS_CLIENT) start_field(P_FIXED, 37); else m_ph = P_DONE;
        end else begin
          m_st = tchfe_pkg::ST_REJ; m_ph = P_DONE;
        end
      end
      P_FIXED: begin
        if (m_fleft > 0) m_fleft--;
        if (m_fleft == 0) m_ph = fits(1) ? P_SIDLEN : P_DONE;
      end
      P_SIDLEN: begin
        if (!fits(b)) m_ph = P_DONE;
        else if (b == 0) begin_clen();
        else start_field(P_SID, b);
      end
      P_SID: begin
        if (m_fleft > 0) m_fleft--;
        if (m_fleft == 0) begin_clen();
      end
      P_CLEN: begin
        if (collect(b)) begin
          v = m_acc;
          if (!fits(v)) m_ph = P_DONE;
          else if (v == 0) begin_complen();
          else begin start_field(P_CIPH, v); m_exts = v; end
        end
      end
      P_CIPH: begin
        idx = m_exts - m_fleft;
        if (idx == 0 || idx == 2) m_acc = b;
        else if (idx == 1 && m_exts >= 2) m_s1 = {m_acc[7:0], b};
        else if (idx == 3 && m_exts >= 4) m_s2 = {m_acc[7:0], b};
        if (m_fleft > 0) m_fleft--;
        if (m_fleft == 0) begin m_exts = 0; begin_complen(); end
      end
      P_COMPLEN: begin
        if (!fits(b)) m_ph = P_DONE;
        else if (b == 0) begin_elen();
        else start_field(P_COMP, b);
      end
      P_COMP: begin
        if (m_fleft > 0) m_fleft--;
        if (m_fleft == 0) begin_elen();
      end
      P_ELEN: begin
        if (collect(b)) begin
          v = m_acc;
          if (!fits(v)) m_ph = P_DONE;
          else begin m_exts = v; begin_walk(); end
        end
      end
      P_EHDR: begin
        eat_body();
        if (collect(b)) begin
          v = m_acc;
          if (m_etype <= tchfe_pkg::EXT_MAP_TOP) m_map[m_etype[5:0]] = 1'b1;
          if (!fits(v)) m_ph = P_DONE;
          else begin
            m_cnt++;
            m_ext = v;
            if (m_etype == tchfe_pkg::EXT_SNI && v >= 2) start_field(P_SNI_LIST, 2);
            else if (m_etype == tchfe_pkg::EXT_ALPN && v >= 2) start_field(P_ALPN_LIST, 2);
            else begin_rest();
          end
        end else if (m_fleft == 2) begin
          m_etype = m_acc; m_acc = 0;
        end
      end
      P_SNI_LIST: begin
        eat_body();
        if (collect(b)) begin
          if (m_acc >= 3 && m_ext >= 3) m_ph = P_SNI_TYPE; else begin_rest();
        end
      end
      P_SNI_TYPE: begin
        eat_body();
        if (b == tchfe_pkg::SNI_HOST && m_ext >= 2) start_field(P_SNI_NLEN, 2);
        else begin_rest();
      end
      P_SNI_NLEN: begin
        eat_body();
        if (collect(b)) begin
          v = m_acc;
          if (v > 0 && v <= m_ext && m_sni == 0) start_field(P_SNI_NAME, v);
          else begin_rest();
        end
      end
      P_SNI_NAME: begin
        eat_body();
        if (m_sni < SNI_CAP) begin name_word(tchfe_pkg::KIND_SNI, b); m_sni++; end
        if (m_fleft > 0) m_fleft--;
        if (m_fleft == 0) begin_rest();
      end
      P_ALPN_LIST: begin
        eat_body();
        if (collect(b)) begin
          if (m_acc >= 1 && m_ext >= 1) m_ph = P_ALPN_PLEN; else begin_rest();
        end
      end
      P_ALPN_PLEN: begin
        eat_body();
        if (b > 0 && b <= m_ext && m_alpn == 0) start_field(P_ALPN_NAME, b);
        else begin_rest();
      end
      P_ALPN_NAME: begin
        eat_body();
        if (m_alpn < ALPN_CAP) begin name_word(tchfe_pkg::KIND_ALPN, b); m_alpn++; end
        if (m_fleft > 0) m_fleft--;
        if (m_fleft == 0) begin_rest();
      end
      P_ESKIP: begin
        eat_body();
        if (m_ext == 0) end_ext();
      end
      default: m_ph = P_DONE;
    endcase
    if (m_off < 16'hffff) m_off++;
    if (it.last_byte) begin
      ok = (m_st == tchfe_pkg::ST_CH || m_st == tchfe_pkg::ST_OTHER);
      s = '0;
      s.kind = tchfe_pkg::KIND_SUMMARY;
      s.status = ok ? m_st : tchfe_pkg::ST_REJ;
      if (ok) begin
        s.hs_type = m_hs; s.record_version = m_ver;
        s.cipher_first = m_s1; s.cipher_second = m_s2;
        s.extension_count = m_cnt; s.extension_bitmap = m_map;
        s.sni_length = m_sni; s.alpn_length = m_alpn;
      end
      s.run_end = 1'b1;
      expected_words.push_back(s);
      clear_pkt();
    end
  endfunction

  // send one word, honoring full; the model runs at acceptance
  task automatic send_word(tchfe_pkg::in_t it);
    item <= it;
    push <= 1'b1;
    do @(posedge clk); while (full);
    parse_byte(it);
    if ($urandom_range(0, 3) == 0 && gap_max > 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
    end
  endtask

  task automatic idle_push();
    push <= 1'b0;
  endtask

  // packet byte buffer built by the tests
  logic [7:0] pkt[$];

  task automatic send_packet(int plen, bit mark_last = 1);
    tchfe_pkg::in_t it;
    for (int i = 0; i < pkt.size(); i++) begin
      it.data_byte = pkt[i];
      it.packet_length = plen[15:0];
      it.last_byte = mark_last && (i == pkt.size() - 1);
      send_word(it);
    end
  endtask

  function automatic void put16(int v);
    pkt.push_back(v[15:8]); pkt.push_back(v[7:0]);
  endfunction

  // build a ClientHello with random content; cut truncates it at a random byte
  function automatic void build_hello(int n_ext, int sni_len, int alpn_size, bit cut);
    logic [7:0] body[$];
    logic [7:0] exts[$];
    int sid, nc, t, l;
    pkt.delete();
    sid = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 32);
    nc = $urandom_range(0, 4);
    // extensions
    for (int e = 0; e < n_ext; e++) begin
      t = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 70);
      if (e == 0 && sni_len > 0) t = tchfe_pkg::EXT_SNI;
      if (e == 1 && alpn_size > 0) t = tchfe_pkg::EXT_ALPN;
      exts.push_back(t[15:8]); exts.push_back(t[7:0]);
      if (t == tchfe_pkg::EXT_SNI && sni_len > 0) begin
        l = sni_len + 5;
        exts.push_back(l[15:8]); exts.push_back(l[7:0]);
        l = sni_len + 3;
        exts.push_back(l[15:8]); exts.push_back(l[7:0]);
        exts.push_back(tchfe_pkg::SNI_HOST);
        exts.push_back(sni_len >> 8); exts.push_back(sni_len[7:0]);
        for (int k = 0; k < sni_len; k++) exts.push_back($urandom_range(0, 255));
      end else if (t == tchfe_pkg::EXT_ALPN && alpn_size > 0) begin
        l = alpn_size + 3;
        exts.push_back(l[15:8]); exts.push_back(l[7:0]);
        l = alpn_size + 1;
        exts.push_back(l[15:8]); exts.push_back(l[7:0]);
        exts.push_back(alpn_size[7:0]);
        for (int k = 0; k < alpn_size; k++) exts.push_back($urandom_range(0, 255));
      end else begin
        l = $urandom_range(0, ext_body_max);
        exts.push_back(8'd0); exts.push_back(l[7:0]);
        for (int k = 0; k < l; k++) exts.push_back($urandom_range(0, 255));
      end
    end
    body.push_back(tchfe_pkg::HS_CLIENT);
    body.push_back(0); body.push_back(0); body.push_back(0);
    for (int k = 0; k < 34; k++) body.push_back($urandom_range(0, 255));
    body.push_back(sid[7:0]);
    for (int k = 0; k < sid; k++) body.push_back($urandom_range(0, 255));
    body.push_back(0); body.push_back(8'(2 * nc));
    for (int k = 0; k < 2 * nc; k++) body.push_back($urandom_range(0, 255));
    body.push_back(1); body.push_back(0);
    body.push_back(8'(exts.size() >> 8)); body.push_back(8'(exts.size()));
    foreach (exts[k]) body.push_back(exts[k]);
    pkt.push_back(tchfe_pkg::CT_HANDSHAKE);
    pkt.push_back(3); pkt.push_back($urandom_range(0, 4));
    put16(body.size());
    foreach (body[k]) pkt.push_back(body[k]);
    if (cut) pkt = pkt[0:$urandom_range(0, pkt.size() - 1)];
  endfunction

  task automatic hello_packet(int n_ext, int sni_len, int alpn_size);
    int plen;
    bit cut;
    cut = $urandom_range(0, 7) == 0;
    build_hello(n_ext, sni_len, alpn_size, cut);
    plen = pkt.size();
    // sometimes lie about the length to hit the fit checks
    if ($urandom_range(0, 7) == 0) plen = $urandom_range(0, plen + 4);
    send_packet(plen);
  endtask

  task automatic test_rejects();
    // wrong content type, bad handshake type, too-short and empty-ish packets
    pkt = '{8'h17, 8'h03, 8'h03, 8'h00, 8'h01, 8'h01};
    send_packet(6);
    pkt = '{tchfe_pkg::CT_HANDSHAKE, 8'h03, 8'h01, 8'h00, 8'h01, 8'h04};
    send_packet(6);
    pkt = '{tchfe_pkg::CT_HANDSHAKE, 8'h03};
    send_packet(2);
    pkt = '{tchfe_pkg::CT_HANDSHAKE, 8'h03, 8'h03, 8'h00, 8'h09, tchfe_pkg::HS_CLIENT};
    send_packet(6);
    pkt = '{8'hff};
    send_packet(16'hffff);
  endtask

  task automatic test_other_handshakes();
    pkt = '{tchfe_pkg::CT_HANDSHAKE, 8'hff, 8'hff, 8'h00, 8'h02, tchfe_pkg::HS_SERVER,
            8'h00};
    send_packet(7);
    pkt = '{tchfe_pkg::CT_HANDSHAKE, 8'h03, 8'h03, 8'h00, 8'h01, tchfe_pkg::HS_CERT};
    send_packet(6);
  endtask

  task automatic test_directed_hellos();
    // name past the capture limit, name cut by packet end, no extensions
    build_hello(3, 260, 40, 0); send_packet(pkt.size());
    build_hello(2, 10, 5, 0);
    pkt = pkt[0:pkt.size() - 4];
    send_packet(pkt.size() + 3);
    build_hello(0, 0, 0, 0); send_packet(pkt.size());
    build_hello(4, 1, 1, 0); send_packet(pkt.size());
  endtask

  task automatic test_extension_limit();
    // empty extension bodies keep the packet short
    ext_body_max = 0;
    build_hello(256, 0, 0, 0); send_packet(pkt.size());
    ext_body_max = 6;
  endtask

  task automatic test_overlong_packet();
    tchfe_pkg::in_t it;
    build_hello(2, 4, 3, 0);
    send_packet(pkt.size(), 0);
    // trailing bytes past the length, with packet_length at or near 16'hffff
    for (int i = 0; i < 6; i++) begin
      it.data_byte = $urandom_range(0, 255);
      it.packet_length = 16'hffff ^ 16'(i);
      it.last_byte = (i == 5);
      send_word(it);
    end
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 100) begin
      case ($urandom_range(0, 9))
        0: begin
          // noise packet
          pkt.delete();
          for (int k = $urandom_range(1, 12); k > 0; k--) pkt.push_back($urandom_range(0, 255));
          send_packet($urandom_range(0, 65535));
        end
        1: begin
          build_hello($urandom_range(0, 3), 0, 0, 0);
          pkt[5] = $urandom_range(0, 12);
          send_packet(pkt.size());
        end
        default: hello_packet($urandom_range(0, 6), $urandom_range(0, 3) == 0 ? 0 :
                              $urandom_range(1, 40), $urandom_range(0, 3) == 0 ? 0 :
                              $urandom_range(1, 40));
      endcase
      sent += pkt.size();
      if ($urandom_range(0, 5) == 0) begin
        idle_push();
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      gap_max = $urandom_range(0, 2) == 0 ? 0 : 4;
    end
  endtask

  task automatic test_backpressure();
    // the receiver takes the request and holds off on its own count
    hold_off = 1;
    gap_max = 0;
    build_hello(2, 30, 20, 0);
    send_packet(pkt.size());
    gap_max = 4;
  endtask

  // receiver: stall pattern, plus a long hold-off on request
  initial begin
    int hold;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        pop <= 1'b0;
        hold_off = 0;
        hold = 0;
        while (hold < 200) begin @(posedge clk); hold++; end
      end
      case (cycles % 64 / 16)
        0: pop <= 1'b1;
        1: pop <= $urandom_range(0, 3) != 0;
        default: pop <= $urandom_range(0, 1);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    tchfe_pkg::out_t w;
    if (!rst && pop && !empty) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word %h", result);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if (result.kind !== w.kind) begin
          $error("kind exp %0d got %0d", w.kind, result.kind); errors++;
        end
        if (result.name_byte !== w.name_byte) begin
          $error("name_byte exp %h got %h", w.name_byte, result.name_byte); errors++;
        end
        if (result.status !== w.status) begin
          $error("status exp %0d got %0d", w.status, result.status); errors++;
        end
        if (result.hs_type !== w.hs_type) begin
          $error("hs_type exp %h got %h", w.hs_type, result.hs_type);
          errors++;
        end
        if (result.record_version !== w.record_version) begin
          $error("record_version exp %h got %h", w.record_version, result.record_version);
          errors++;
        end
        if (result.cipher_first !== w.cipher_first) begin
          $error("cipher_first exp %h got %h", w.cipher_first, result.cipher_first);
          errors++;
        end
        if (result.cipher_second !== w.cipher_second) begin
          $error("cipher_second exp %h got %h", w.cipher_second, result.cipher_second);
          errors++;
        end
        if (result.extension_count !== w.extension_count) begin
          $error("extension_count exp %0d got %0d", w.extension_count,
                 result.extension_count);
          errors++;
        end
        if (result.extension_bitmap !== w.extension_bitmap) begin
          $error("extension_bitmap exp %h got %h", w.extension_bitmap,
                 result.extension_bitmap);
          errors++;
        end
        if (result.sni_length !== w.sni_length) begin
          $error("sni_length exp %0d got %0d", w.sni_length, result.sni_length); errors++;
        end
        if (result.alpn_length !== w.alpn_length) begin
          $error("alpn_length exp %0d got %0d", w.alpn_length, result.alpn_length);
          errors++;
        end
        if (result.run_end !== w.run_end) begin
          $error("run_end exp %0d got %0d", w.run_end, result.run_end); errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    clear_pkt();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_rejects();
    test_other_handshakes();
    test_directed_hellos();
    test_backpressure();
    test_extension_limit();
    test_overlong_packet();
    test_random();
    idle_push();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
